// ===== rtl/boolean_rpn_stack_evaluator_top_macros.svh =====
// assertion macros for the boolean postfix evaluator
// used by boolean_rpn_stack_evaluator_top; expects i_clk and i_rst_n in scope
`ifndef BOOLEAN_RPN_STACK_EVALUATOR_TOP_MACROS_SVH
`define BOOLEAN_RPN_STACK_EVALUATOR_TOP_MACROS_SVH

// property sampled on the rising clock, off while reset is held
`define BRSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication
`define BRSE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/brse_pkg.sv =====
// shared constants, opcodes and stack cell command type
// for the boolean postfix evaluator; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package brse_pkg;

    localparam int STACK_SLOTS  = 16;
    localparam int MAX_OPERANDS = 8;

    localparam int OPCODE_W = 3;
    localparam int COUNT_W  = 8;
    localparam int OPTION_W = 64;
    localparam int FILL_W   = $clog2(STACK_SLOTS + 1);
    localparam int REM_W    = $clog2(MAX_OPERANDS + 1);

    localparam logic [COUNT_W-1:0] MAX_OPS_CNT = COUNT_W'(MAX_OPERANDS);
    localparam logic [FILL_W-1:0]  FULL_FILL   = FILL_W'(STACK_SLOTS);

    typedef enum logic [OPCODE_W-1:0] {
        OP_LEAF_DONE = 3'd0,
        OP_LEAF_EQ   = 3'd1,
        OP_ALL       = 3'd2,
        OP_ANY       = 3'd3,
        OP_NEGATE    = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_MERGE_AND,
        CELL_MERGE_OR,
        CELL_FLIP,
        CELL_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     push_bit;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== rtl/boolean_rpn_stack_evaluator_top.sv =====
// leaf and negate beats act on the stack from the idle state; all/any do arg_count-1
// pairwise merges, one merge per cycle through the cell chain; an end beat
// then waits in the finish state while the previous result still waits on i_stall
// o_stall is high outside the idle state, so the block takes one beat at a time
// reset: synchronous active-low i_rst_n empties stack and sticky error, drops o_valid
`timescale 1ns / 1ps
`default_nettype none
`include "boolean_rpn_stack_evaluator_top_macros.svh"

module boolean_rpn_stack_evaluator_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // instruction channel
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire [brse_pkg::OPCODE_W-1:0]     i_opcode,
    input  wire [brse_pkg::COUNT_W-1:0]      i_arg_count,
    input  wire                              i_objective_done,
    input  wire [brse_pkg::OPTION_W-1:0]     i_chosen_option,
    input  wire [brse_pkg::OPTION_W-1:0]     i_wanted_option,
    input  wire                              i_end_of_program,
    // result channel
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic                             o_truth,
    output logic                             o_fault
);

    // sequencer states: idle takes a beat, reduce keeps merging the top two
    // entries, finish hands the program result to the output register
    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_FINISH
    } t_state;

    t_state                      r_state, n_state;
    logic [brse_pkg::FILL_W-1:0] r_fill, n_fill;
    logic                        r_err, n_err;
    logic [brse_pkg::REM_W-1:0]  r_rem, n_rem;
    logic                        r_is_or, n_is_or;
    logic                        r_last, n_last;
    logic                        r_out_valid, n_out_valid;
    logic                        r_truth, n_truth;
    logic                        r_fault, n_fault;

    brse_pkg::t_cell_cmd         w_cmd;
    logic                        w_leaf_bit;
    logic                        w_cell_bit [brse_pkg::STACK_SLOTS];
    logic                        w_count_bad;
    logic                        w_too_few;

    // value pushed by the two leaf kinds
    assign w_leaf_bit = (brse_pkg::t_opcode'(i_opcode) == brse_pkg::OP_LEAF_EQ)
                      ? (i_chosen_option == i_wanted_option)
                      : i_objective_done;

    // all/any checks: count out of range or not enough entries on the stack
    assign w_count_bad = (i_arg_count < brse_pkg::COUNT_W'(2))
                      || (i_arg_count > brse_pkg::MAX_OPS_CNT);
    assign w_too_few   = brse_pkg::COUNT_W'(r_fill) < i_arg_count;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_err       = r_err;
        n_rem       = r_rem;
        n_is_or     = r_is_or;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_stall;
        n_truth     = r_truth;
        n_fault     = r_fault;
        w_cmd.op       = brse_pkg::CELL_HOLD;
        w_cmd.push_bit = w_leaf_bit;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_last  = i_end_of_program;
                    n_state = i_end_of_program ? S_FINISH : S_IDLE;
                    // once an error is seen the rest of the program is skipped
                    if (!r_err) begin
                        unique case (brse_pkg::t_opcode'(i_opcode)) inside
                            brse_pkg::OP_LEAF_DONE, brse_pkg::OP_LEAF_EQ: begin
                                if (r_fill == brse_pkg::FULL_FILL) begin
                                    n_err = 1'b1;
                                end else begin
                                    w_cmd.op = brse_pkg::CELL_PUSH;
                                    n_fill   = r_fill + brse_pkg::FILL_W'(1);
                                end
                            end
                            brse_pkg::OP_ALL, brse_pkg::OP_ANY: begin
                                if (w_count_bad || w_too_few) begin
                                    n_err = 1'b1;
                                end else begin
                                    // first merge happens right away
                                    n_is_or  = (brse_pkg::t_opcode'(i_opcode)
                                                == brse_pkg::OP_ANY);
                                    w_cmd.op = n_is_or ? brse_pkg::CELL_MERGE_OR
                                                       : brse_pkg::CELL_MERGE_AND;
                                    n_fill   = r_fill - brse_pkg::FILL_W'(1);
                                    if (i_arg_count > brse_pkg::COUNT_W'(2)) begin
                                        n_rem   = brse_pkg::REM_W'(i_arg_count
                                                  - brse_pkg::COUNT_W'(2));
                                        n_state = S_REDUCE;
                                    end
                                end
                            end
                            brse_pkg::OP_NEGATE: begin
                                if (i_arg_count != brse_pkg::COUNT_W'(1)
                                    || r_fill == '0) begin
                                    n_err = 1'b1;
                                end else begin
                                    w_cmd.op = brse_pkg::CELL_FLIP;
                                end
                            end
                            default: n_err = 1'b1;
                        endcase
                    end
                end
            end
            S_REDUCE: begin
                w_cmd.op = r_is_or ? brse_pkg::CELL_MERGE_OR : brse_pkg::CELL_MERGE_AND;
                n_fill   = r_fill - brse_pkg::FILL_W'(1);
                n_rem    = r_rem - brse_pkg::REM_W'(1);
                if (r_rem == brse_pkg::REM_W'(1)) begin
                    n_state = r_last ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH: begin
                // wait for a free output slot, then report and empty the stack
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_fault     = r_err || (r_fill != brse_pkg::FILL_W'(1));
                    n_truth     = n_fault ? 1'b0 : w_cell_bit[0];
                    w_cmd.op    = brse_pkg::CELL_CLEAR;
                    n_fill      = '0;
                    n_err       = 1'b0;
                    n_last      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_err       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_err       <= n_err;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        r_rem   <= n_rem;
        r_is_or <= n_is_or;
        r_truth <= n_truth;
        r_fault <= n_fault;
    end

    // stack as a chain of bit cells, cell 0 is the top of stack
    for (genvar g = 0; g < brse_pkg::STACK_SLOTS; g++) begin : g_cell
        logic w_above;
        logic w_below;
        if (g == 0) begin : g_top
            assign w_above = w_cmd.push_bit;
        end else begin : g_mid
            assign w_above = w_cell_bit[g-1];
        end
        if (g == brse_pkg::STACK_SLOTS - 1) begin : g_bottom
            assign w_below = 1'b0;
        end else begin : g_link
            assign w_below = w_cell_bit[g+1];
        end
        brse_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_is_top     (1'(g == 0)),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_bit        (w_cell_bit[g])
        );
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_truth = r_truth;
    assign o_fault = r_fault;

    `BRSE_ASSERT(a_fill_bound, r_fill <= brse_pkg::FULL_FILL, "stack fill above depth")
    `BRSE_ASSERT_IMPL(a_reduce_operands, r_state == S_REDUCE,
        r_fill >= brse_pkg::FILL_W'(2) && r_rem != '0, "merge without two entries")
    `BRSE_ASSERT_IMPL(a_result_source, $rose(r_out_valid),
        $past(r_state) == S_FINISH, "result raised outside finish")
    `BRSE_ASSERT_IMPL(a_clear_after_end, $rose(r_out_valid),
        r_fill == '0 && !r_err, "stack not emptied after program end")

endmodule

`default_nettype wire

// ===== rtl/brse_cell.sv =====
// one bit of the evaluation stack, linked to its neighbors
// depends on brse_pkg for the command type
`timescale 1ns / 1ps
`default_nettype none

module brse_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  brse_pkg::t_cell_cmd  i_cmd,
    input  wire                  i_is_top,
    input  wire                  i_from_above,
    input  wire                  i_from_below,
    output logic                 o_bit
);

    logic r_bit;
    logic n_bit;

    always_comb begin
        n_bit = r_bit;
        unique case (i_cmd.op)
            brse_pkg::CELL_HOLD:      n_bit = r_bit;
            brse_pkg::CELL_PUSH:      n_bit = i_from_above;
            // top cell folds its neighbor in, the rest move up one place
            brse_pkg::CELL_MERGE_AND: n_bit = i_is_top ? (r_bit & i_from_below) : i_from_below;
            brse_pkg::CELL_MERGE_OR:  n_bit = i_is_top ? (r_bit | i_from_below) : i_from_below;
            brse_pkg::CELL_FLIP:      n_bit = i_is_top ? ~r_bit : r_bit;
            brse_pkg::CELL_CLEAR:     n_bit = 1'b0;
            default:                  n_bit = r_bit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

`default_nettype wire

// ===== tb/sv/brse_result_checker.sv =====
// result checker for boolean_rpn_stack_evaluator_top: watches both channels,
// predicts each program's verdict and compares it; depends on brse_pkg
`timescale 1ns / 1ps

module brse_result_checker
    import brse_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // instruction channel
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  wire [OPCODE_W-1:0]  i_opcode,
    input  wire [COUNT_W-1:0]   i_arg_count,
    input  wire                 i_objective_done,
    input  wire [OPTION_W-1:0]  i_chosen_option,
    input  wire [OPTION_W-1:0]  i_wanted_option,
    input  wire                 i_end_of_program,
    // result channel
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  wire                 i_truth,
    input  wire                 i_fault,
    output int                  o_pending,
    output int                  o_mismatches
);

    typedef struct packed {
        logic truth;
        logic fault;
    } t_verdict;

    bit       bit_stack [STACK_SLOTS];
    int       fill_level = 0;
    bit       sticky_err = 1'b0;
    t_verdict verdict_q [$];
    int       mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    task automatic clear_program();
        foreach (bit_stack[i])
            bit_stack[i] = 1'b0;
        fill_level = 0;
        sticky_err = 1'b0;
    endtask

    // runs one instruction on the shadow stack; an end beat yields a verdict
    task automatic eval_instruction(
        input logic [OPCODE_W-1:0] op,
        input logic [COUNT_W-1:0]  cnt,
        input logic                done,
        input logic [OPTION_W-1:0] chosen,
        input logic [OPTION_W-1:0] wanted,
        input logic                last
    );
        bit       acc;
        int       base;
        t_verdict v;
        if (!sticky_err) begin
            case (op) inside
                OP_LEAF_DONE, OP_LEAF_EQ: begin
                    if (fill_level >= STACK_SLOTS) begin
                        sticky_err = 1'b1;
                    end else begin
                        bit_stack[fill_level] = (op == OP_LEAF_DONE) ? done
                                                                     : (chosen == wanted);
                        fill_level++;
                    end
                end
                OP_ALL, OP_ANY: begin
                    if (cnt < 2 || cnt > MAX_OPERANDS || fill_level < cnt) begin
                        sticky_err = 1'b1;
                    end else begin
                        base = fill_level - cnt;
                        acc  = (op == OP_ALL);
                        for (int i = base; i < fill_level; i++)
                            acc = (op == OP_ALL) ? (acc & bit_stack[i]) : (acc | bit_stack[i]);
                        bit_stack[base] = acc;
                        fill_level      = base + 1;
                    end
                end
                OP_NEGATE: begin
                    if (cnt != 1 || fill_level == 0)
                        sticky_err = 1'b1;
                    else
                        bit_stack[fill_level-1] = ~bit_stack[fill_level-1];
                end
                default: sticky_err = 1'b1;
            endcase
        end
        if (last) begin
            v.fault = sticky_err || (fill_level != 1);
            v.truth = v.fault ? 1'b0 : bit_stack[0];
            verdict_q.push_back(v);
            clear_program();
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            clear_program();
        end else begin
            // a result taken at this edge belongs to an earlier program end
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("result truth=%0b fault=%0b with no program end",
                                              i_truth, i_fault));
                end else begin
                    want = verdict_q.pop_front();
                    if (i_truth !== want.truth)
                        report_mismatch($sformatf("truth %0b, expected %0b", i_truth, want.truth));
                    if (i_fault !== want.fault)
                        report_mismatch($sformatf("fault %0b, expected %0b", i_fault, want.fault));
                end
            end
            if (i_in_valid && !i_in_stall)
                eval_instruction(i_opcode, i_arg_count, i_objective_done,
                                 i_chosen_option, i_wanted_option, i_end_of_program);
        end
        o_pending <= verdict_q.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for boolean_rpn_stack_evaluator_top: builds instruction programs,
// drives both channels and gives the verdict; depends on brse_pkg and brse_result_checker
`timescale 1ns / 1ps

module tb;
    import brse_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int IDLE_PCT      = 13;
    localparam int RANDOM_ITEMS  = 1130;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 4 * MAX_OPERANDS;
    localparam int CYCLE_LIMIT   = 300000;

    // opcodes the block must reject
    localparam logic [OPCODE_W-1:0] OPC_FIRST_UNKNOWN = 3'd5;
    localparam logic [OPCODE_W-1:0] OPC_LAST_UNKNOWN  = 3'd7;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [COUNT_W-1:0]  count;
        logic                done;
        logic [OPTION_W-1:0] chosen;
        logic [OPTION_W-1:0] wanted;
        logic                last;
    } t_beat;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [OPCODE_W-1:0] opcode;
    logic [COUNT_W-1:0]  arg_count;
    logic                objective_done;
    logic [OPTION_W-1:0] chosen_option;
    logic [OPTION_W-1:0] wanted_option;
    logic                end_of_program;
    logic                out_valid;
    logic                out_stall;
    logic                truth;
    logic                fault;

    int pending;
    int mismatches;

    t_beat prog_q [$];
    int    items_sent   = 0;
    bit    calm         = 1'b0;   // no idling on either side while set
    int    hold_asks    = 0;      // requests for a long receiver hold-off
    int    holds_served = 0;
    int    cycle_count  = 0;

    always #CLK_HALF clk = ~clk;

    boolean_rpn_stack_evaluator_top uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_opcode         (opcode),
        .i_arg_count      (arg_count),
        .i_objective_done (objective_done),
        .i_chosen_option  (chosen_option),
        .i_wanted_option  (wanted_option),
        .i_end_of_program (end_of_program),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_truth          (truth),
        .o_fault          (fault)
    );

    brse_result_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_arg_count      (arg_count),
        .i_objective_done (objective_done),
        .i_chosen_option  (chosen_option),
        .i_wanted_option  (wanted_option),
        .i_end_of_program (end_of_program),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_truth          (truth),
        .i_fault          (fault),
        .o_pending        (pending),
        .o_mismatches     (mismatches)
    );

    // watchdog: a hung block or a lost result ends here
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random back-pressure, plus a long hold-off on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_asks != holds_served) begin
                holds_served++;
                out_stall <= 1'b1;
                // sender keeps offering beats so the block backs up into o_stall
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else begin
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // exact beat, for the directed programs
    task automatic add_exact(
        input logic [OPCODE_W-1:0] op,
        input logic [COUNT_W-1:0]  cnt,
        input logic                done,
        input logic [OPTION_W-1:0] chosen,
        input logic [OPTION_W-1:0] wanted,
        input logic                last
    );
        t_beat b;
        b = '{opcode: op, count: cnt, done: done, chosen: chosen, wanted: wanted, last: last};
        prog_q.push_back(b);
    endtask

    // beat with the given opcode and count; end mark clear, every other field random
    task automatic add_beat(input logic [OPCODE_W-1:0] op, input logic [COUNT_W-1:0] cnt);
        t_beat b;
        b.opcode = op;
        b.count  = cnt;
        b.done   = $urandom_range(0, 1);
        b.chosen = {$urandom, $urandom};
        // equal keys half the time, near misses often, so both leaf answers show up
        case ($urandom_range(0, 3)) inside
            0, 1:    b.wanted = b.chosen;
            2:       b.wanted = b.chosen ^ (64'd1 << $urandom_range(0, OPTION_W - 1));
            default: b.wanted = {$urandom, $urandom};
        endcase
        b.last = 1'b0;
        prog_q.push_back(b);
    endtask

    task automatic add_leaf();
        add_beat($urandom_range(0, 1) ? OP_LEAF_DONE : OP_LEAF_EQ, $urandom_range(0, 255));
    endtask

    task automatic add_merge(input int depth);
        int top;
        top = (depth < MAX_OPERANDS) ? depth : MAX_OPERANDS;
        add_beat($urandom_range(0, 1) ? OP_ALL : OP_ANY, $urandom_range(2, top));
    endtask

    task automatic mark_end();
        prog_q[prog_q.size() - 1].last = 1'b1;
    endtask

    // well-formed postfix program: the stack never overflows or underflows
    // and is folded down to one entry at the end
    task automatic build_good();
        int depth;
        int target;
        int leaf_pct;
        depth    = 0;
        target   = $urandom_range(1, 24);
        leaf_pct = ($urandom_range(0, 3) == 0) ? 95 : $urandom_range(45, 75);
        for (int s = 0; s < target; s++) begin
            if (depth < 2 || (depth < STACK_SLOTS && $urandom_range(0, 99) < leaf_pct)) begin
                add_leaf();
                depth++;
            end else if ($urandom_range(0, 4) == 0) begin
                add_beat(OP_NEGATE, 1);
            end else begin
                add_merge(depth);
                depth = depth - prog_q[prog_q.size() - 1].count + 1;
            end
        end
        while (depth > 1) begin
            add_merge(depth);
            depth = depth - prog_q[prog_q.size() - 1].count + 1;
        end
        mark_end();
    endtask

    // well-formed program with one defect spliced in, or replaced by a stack overflow
    task automatic build_broken();
        int    pos;
        t_beat b;
        build_good();
        pos = $urandom_range(0, prog_q.size() - 1);
        case ($urandom_range(0, 4))
            0: begin
                // one to three pushes past a full stack
                prog_q.delete();
                repeat (STACK_SLOTS + 1 + $urandom_range(0, 2)) add_leaf();
                if ($urandom_range(0, 1))
                    add_merge(MAX_OPERANDS);
                mark_end();
            end
            1: begin
                // count out of range for all/any, or not one for negate
                if ($urandom_range(0, 2) == 0)
                    add_beat(OP_NEGATE, $urandom_range(0, 1) ? 0 : $urandom_range(2, 255));
                else
                    add_beat($urandom_range(0, 1) ? OP_ALL : OP_ANY,
                             $urandom_range(0, 1) ? $urandom_range(0, 1)
                                                  : $urandom_range(MAX_OPERANDS + 1, 255));
                b = prog_q.pop_back();
                prog_q.insert(pos, b);
            end
            2: begin
                add_beat($urandom_range(OPC_FIRST_UNKNOWN, OPC_LAST_UNKNOWN),
                         $urandom_range(0, 255));
                b = prog_q.pop_back();
                prog_q.insert(pos, b);
            end
            3: begin
                // reduction or negate on an empty stack
                if ($urandom_range(0, 2) == 0)
                    add_beat(OP_NEGATE, 1);
                else
                    add_merge(MAX_OPERANDS);
                b = prog_q.pop_back();
                prog_q.insert(0, b);
            end
            default: begin
                // one extra entry left at the end
                prog_q[prog_q.size() - 1].last = 1'b0;
                add_leaf();
                mark_end();
            end
        endcase
    endtask

    // short burst of fully random beats, end marks scattered
    task automatic build_noise();
        repeat ($urandom_range(1, 6)) begin
            add_beat($urandom_range(0, 7), $urandom_range(0, 255));
            prog_q[prog_q.size() - 1].last = ($urandom_range(0, 3) == 0);
        end
        mark_end();
    endtask

    task automatic send_program();
        t_beat b;
        while (prog_q.size() > 0) begin
            b = prog_q.pop_front();
            while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid       <= 1'b1;
            opcode         <= b.opcode;
            arg_count      <= b.count;
            objective_done <= b.done;
            chosen_option  <= b.chosen;
            wanted_option  <= b.wanted;
            end_of_program <= b.last;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            items_sent++;
        end
    endtask

    // stop offering beats until every predicted verdict has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial begin
        int prog_idx;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_LEAF_DONE;
        arg_count      = '0;
        objective_done = 1'b0;
        chosen_option  = '0;
        wanted_option  = '0;
        end_of_program = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed programs
        // lone leaf
        add_exact(OP_LEAF_DONE, 0, 1, 0, 0, 1);
        // equal and unequal keys at the extremes, any, then negate
        add_exact(OP_LEAF_EQ, 8'hFF, 0, '1, '1, 0);
        add_exact(OP_LEAF_EQ, 0, 1, '0, '1, 0);
        add_exact(OP_ANY, 2, 0, 0, 0, 0);
        add_exact(OP_NEGATE, 1, 1, '1, '0, 1);
        // all with a zero count
        add_exact(OP_LEAF_DONE, 0, 0, 0, 0, 0);
        add_exact(OP_ALL, 0, 0, 0, 0, 1);
        // any with the largest count
        add_exact(OP_LEAF_DONE, 0, 1, 0, 0, 0);
        add_exact(OP_LEAF_DONE, 0, 1, 0, 0, 0);
        add_exact(OP_ANY, 8'hFF, 0, 0, 0, 1);
        // negate on an empty stack
        add_exact(OP_NEGATE, 1, 0, 0, 0, 1);
        // negate with a zero count
        add_exact(OP_LEAF_DONE, 0, 1, 0, 0, 0);
        add_exact(OP_NEGATE, 0, 0, 0, 0, 1);
        // unknown opcode as the whole program
        add_exact(OPC_LAST_UNKNOWN, 0, 0, 0, 0, 1);
        // two entries left at the end
        add_exact(OP_LEAF_DONE, 0, 1, 0, 0, 0);
        add_exact(OP_LEAF_DONE, 0, 0, 0, 0, 1);
        // all needing more entries than present
        add_exact(OP_LEAF_DONE, 0, 1, 0, 0, 0);
        add_exact(OP_ALL, 2, 0, 0, 0, 1);
        // beats after an error are ignored, end mark still closes the program
        add_exact(OP_LEAF_DONE, 0, 1, 0, 0, 0);
        add_exact(OPC_FIRST_UNKNOWN, 0, 0, 0, 0, 0);
        add_exact(OP_LEAF_DONE, 0, 1, 0, 0, 1);
        send_program();
        drain_results();

        // random programs: mostly well formed, some broken, some noise
        prog_idx = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (prog_idx == 20)
                hold_asks++;
            if (prog_idx == 50)
                drain_results();
            calm = (items_sent >= 500 && items_sent < 700);
            case ($urandom_range(0, 9)) inside
                0, 1:    build_broken();
                2:       build_noise();
                default: build_good();
            endcase
            send_program();
            prog_idx++;
        end
        calm = 1'b0;
        drain_results();
        // quiet tail: anything that comes out now is unexpected
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
